@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the neighbor average blur block.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, muted while reset is asserted (active-low reset).
`define NABD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define NABD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/nabd_pkg.sv @@
// Types and fixed constants for the neighbor average blur block.
// No dependencies; used by every module of the block but nabd_ram.
package nabd_pkg;

    localparam int DATA_W      = 8;
    localparam int SUM_W       = DATA_W + 2;
    localparam int OUT_COL_W   = 8;
    localparam int OUT_ROW_W   = 7;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 2;
    localparam int LINE_WORD_W = 2 * DATA_W;

    localparam logic [DATA_W-1:0]     DARKEN_RESET = 8'd4;
    localparam logic [APB_ADDR_W-1:0] REG_DARKEN   = 2'd0;

    typedef logic [DATA_W-1:0] t_pix;

    // One request after position decode, handed from the front end to the core.
    typedef struct packed {
        t_pix                 pixel;
        logic                 emit;
        logic                 last;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
    } t_item;

    typedef struct packed {
        t_pix                 value;
        logic [OUT_COL_W-1:0] col;
        logic [OUT_ROW_W-1:0] row;
        logic                 last;
    } t_result;

endpackage

@@ hw/rtl/nabd_ram.sv @@
// Generic synchronous RAM: one write port, two read ports, registered read.
// No dependencies.
module nabd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 162
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Read-first: a read of the entry being written returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ hw/rtl/nabd_cfg.sv @@
// APB-style register file holding the darken amount.
// Depends on nabd_pkg.
module nabd_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nabd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nabd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nabd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output nabd_pkg::t_pix                     o_darken
);

    nabd_pkg::t_pix r_darken;
    logic           w_wr;
    logic           w_sel_darken;

    // Word index is the address above the byte lanes; the lone register
    // decodes every word of the two-bit space, misaligned bytes included.
    assign w_sel_darken = (paddr & ~2'b11) == nabd_pkg::REG_DARKEN;
    assign w_wr         = psel && penable && pwrite && w_sel_darken;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_darken <= nabd_pkg::DARKEN_RESET;
        end else if (w_wr) begin
            r_darken <= pwdata[nabd_pkg::DATA_W-1:0];
        end
    end

    assign prdata   = {{(nabd_pkg::APB_DATA_W - nabd_pkg::DATA_W){1'b0}}, r_darken};
    assign pready   = 1'b1;
    assign o_darken = r_darken;

endmodule

@@ hw/rtl/nabd_core.sv @@
// Line-store read/modify/write core: RAM read, neighbor sum, darken, output register.
// Depends on nabd_pkg, nabd_ram and assert_macros.svh.
`include "assert_macros.svh"

module nabd_core #(
    parameter int DEPTH = 162
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    output logic                     o_req_ready,
    input  nabd_pkg::t_item          i_req,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [$clog2(DEPTH)-1:0] i_addr_next,
    input  nabd_pkg::t_pix           i_darken,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output nabd_pkg::t_result        o_out
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = nabd_pkg::LINE_WORD_W;
    localparam int DW     = nabd_pkg::DATA_W;

    // Stage 1: request waiting on its line-store words.
    logic                r_s1_valid;
    nabd_pkg::t_item     r_s1;
    logic [ADDR_W-1:0]   r_s1_addr;
    logic                r_fwd_a;
    logic                r_fwd_b;
    logic [WORD_W-1:0]   r_fwd_word;
    nabd_pkg::t_pix      r_left;
    logic                r_out_valid;
    nabd_pkg::t_result   r_out;

    logic                w_out_free;
    logic                w_s1_go;
    logic                w_accept;
    logic                w_we;
    logic [WORD_W-1:0]   w_wdata;
    logic [WORD_W-1:0]   w_rdata_a;
    logic [WORD_W-1:0]   w_rdata_b;
    logic [WORD_W-1:0]   w_word_a;
    logic [WORD_W-1:0]   w_word_b;
    nabd_pkg::t_pix      w_center;
    nabd_pkg::t_pix      w_up;
    nabd_pkg::t_pix      w_right;
    logic [nabd_pkg::SUM_W-1:0] w_sum;
    nabd_pkg::t_pix      w_avg;
    nabd_pkg::t_pix      w_val;
    nabd_pkg::t_result   w_res;

    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_s1_go     = r_s1_valid && (!r_s1.emit || w_out_free);
    assign o_req_ready = !r_s1_valid || w_s1_go;
    assign w_accept    = i_req_valid && o_req_ready;

    // Entry word is {row above, row middle}.
    nabd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (r_s1_addr),
        .i_wdata   (w_wdata),
        .i_re      (w_accept),
        .i_raddr_a (i_addr),
        .i_raddr_b (i_addr_next),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // Take the word being written in the read cycle over the stale RAM word.
    assign w_word_a = r_fwd_a ? r_fwd_word : w_rdata_a;
    assign w_word_b = r_fwd_b ? r_fwd_word : w_rdata_b;
    assign w_center = w_word_a[DW-1:0];
    assign w_up     = w_word_a[WORD_W-1:DW];
    assign w_right  = w_word_b[DW-1:0];

    assign w_we    = w_s1_go;
    assign w_wdata = {w_center, r_s1.pixel};

    assign w_sum = nabd_pkg::SUM_W'(r_left) + nabd_pkg::SUM_W'(w_right)
                 + nabd_pkg::SUM_W'(w_up) + nabd_pkg::SUM_W'(r_s1.pixel);
    assign w_avg = w_sum[nabd_pkg::SUM_W-1:2];
    assign w_val = (w_avg > i_darken) ? (w_avg - i_darken) : '0;

    always_comb begin
        w_res.value = w_val;
        w_res.col   = r_s1.col;
        w_res.row   = r_s1.row;
        w_res.last  = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_go && r_s1.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1       <= i_req;
            r_s1_addr  <= i_addr;
            r_fwd_a    <= w_we && (r_s1_addr == i_addr);
            r_fwd_b    <= w_we && (r_s1_addr == i_addr_next);
            r_fwd_word <= w_wdata;
        end
        if (w_s1_go) begin
            r_left <= w_center;
        end
        if (w_s1_go && r_s1.emit) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `NABD_ASSERT(a_fwd_on_collision, i_clk, i_rst_n, (w_accept && w_we && (r_s1_addr == i_addr)) |=> r_fwd_a, "same-entry write during read not forwarded")
    `NABD_ASSERT(a_stall_holds_s1, i_clk, i_rst_n, (r_s1_valid && r_s1.emit && r_out_valid && !i_out_ready) |=> (r_s1_valid && $stable(r_s1_addr)), "stage 1 lost while output stalled")
    `NABD_ASSERT(a_addr_in_range, i_clk, i_rst_n, r_s1_valid |-> (32'(r_s1_addr) < DEPTH), "line address beyond padded width")

endmodule

@@ hw/rtl/neighbor_average_blur_darken.sv @@
// Four-neighbor average blur with darkening. Feed the padded frame, (ACTIVE_WIDTH+2) by
// (ACTIVE_HEIGHT+2) pixels, in raster order, one pixel per request; frame_start on the first
// pixel restarts the position counters, which also wrap by themselves at the end of each row
// and frame. For every interior pixel the block returns ((left+right+up+down) >> 2) minus
// darken_amount, clamped at zero, tagged with its interior column and row; the result comes
// out for the request carrying the pixel below the center, and padding positions produce no
// result. Throughput is one pixel per clock while the output keeps up: the two previous rows
// live in one line RAM of {row above, row middle} words with two read ports, read when a
// request is taken and written back as the request leaves the read stage, where a stalled
// output can hold it, with same-entry forwarding when the next request reads what is being
// written. A result passes from the read stage into the output register, and the input keeps
// flowing while a result waits there, stopping only when a result-bearing pixel would overrun
// a stalled output. The line RAM needs no clearing pass after reset: every entry is written
// during the first two padded rows before any result reads it. darken_amount (reset 4) sits
// at APB byte address 0; the user must write it only while the stream is idle (not enforced).
module neighbor_average_blur_darken #(
    parameter int ACTIVE_WIDTH  = 160,
    parameter int ACTIVE_HEIGHT = 120
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel requests
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [nabd_pkg::DATA_W-1:0]        i_pixel_value,
    input  logic                               i_frame_start,
    // results
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [nabd_pkg::DATA_W-1:0]        o_blurred_value,
    output logic [nabd_pkg::OUT_COL_W-1:0]     o_out_column,
    output logic [nabd_pkg::OUT_ROW_W-1:0]     o_out_row,
    output logic                               o_frame_last,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [nabd_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nabd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nabd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    localparam int PADDED_WIDTH  = ACTIVE_WIDTH + 2;
    localparam int PADDED_HEIGHT = ACTIVE_HEIGHT + 2;
    localparam int COL_W         = $clog2(PADDED_WIDTH);
    localparam int ROW_W         = $clog2(PADDED_HEIGHT);
    localparam int OCW           = nabd_pkg::OUT_COL_W;
    localparam int ORW           = nabd_pkg::OUT_ROW_W;

    // Padded position of the next pixel.
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     n_col;
    logic [ROW_W-1:0]     n_row;

    logic [COL_W-1:0]     w_col;
    logic [ROW_W-1:0]     w_row;
    logic                 w_col_end;
    logic                 w_row_end;
    logic                 w_accept;
    logic [COL_W-1:0]     w_col_m1;
    logic [ROW_W-1:0]     w_row_m2;
    logic [COL_W+OCW-1:0] w_col_ext;
    logic [ROW_W+ORW-1:0] w_row_ext;
    nabd_pkg::t_item      w_req;
    nabd_pkg::t_pix       w_darken;
    nabd_pkg::t_result    w_res;

    // frame_start forces the current pixel to padded (0, 0).
    assign w_col     = i_frame_start ? '0 : r_col;
    assign w_row     = i_frame_start ? '0 : r_row;
    assign w_col_end = (w_col == COL_W'(PADDED_WIDTH - 1));
    assign w_row_end = (w_row == ROW_W'(PADDED_HEIGHT - 1));
    assign w_accept  = i_in_valid && o_in_ready;

    // Advance column, wrap into the next row, wrap the frame.
    always_comb begin
        n_col = w_col_end ? '0 : w_col + 1'b1;
        n_row = w_row;
        if (w_col_end) begin
            n_row = w_row_end ? '0 : w_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Interior coordinates, masked to the result field widths.
    assign w_col_m1  = w_col - 1'b1;
    assign w_row_m2  = w_row - ROW_W'(2);
    assign w_col_ext = {{OCW{1'b0}}, w_col_m1};
    assign w_row_ext = {{ORW{1'b0}}, w_row_m2};

    // Center lies one row up; drop rows 0-1 and the first and last padded column.
    always_comb begin
        w_req.pixel = i_pixel_value;
        w_req.emit  = (w_row >= ROW_W'(2)) && (w_col != '0) && !w_col_end;
        w_req.last  = (w_col == COL_W'(ACTIVE_WIDTH)) && (w_row == ROW_W'(ACTIVE_HEIGHT + 1));
        w_req.col   = w_col_ext[OCW-1:0];
        w_req.row   = w_row_ext[ORW-1:0];
    end

    nabd_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_darken (w_darken)
    );

    // Right neighbor is read at the next column; at the row end it wraps to 0
    // and only feeds a padding position that is dropped.
    nabd_core #(
        .DEPTH (PADDED_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .o_req_ready (o_in_ready),
        .i_req       (w_req),
        .i_addr      (w_col),
        .i_addr_next (n_col),
        .i_darken    (w_darken),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (w_res)
    );

    assign o_blurred_value = w_res.value;
    assign o_out_column    = w_res.col;
    assign o_out_row       = w_res.row;
    assign o_frame_last    = w_res.last;

endmodule
